// ----- hdl/alarm_timer_queue_unit_assert.svh -----
// Assertion macros used by the alarm timer queue back end.
`ifndef ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH
`define ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define ATQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("alarm timer queue invariant violated");

// A condition that, once seen, forces another one at the next edge.
`define ATQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("alarm timer queue sequencing violated");

`endif

// ----- hdl/atq_pkg.sv -----
// Shared types, codes and constants of the alarm timer queue.
`timescale 1ns / 1ps
package atq_pkg;

  localparam int MAX_ALARMS_DEF = 64;
  localparam int TICK_BITS = 32;
  localparam logic [31:0] TICK_MASK =
    (TICK_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TICK_BITS) - 64'd1);

  // Request codes.
  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_SET_REL = 3'd1;
  localparam logic [2:0] OP_SET_ABS = 3'd2;
  localparam logic [2:0] OP_CANCEL  = 3'd3;
  localparam logic [2:0] OP_POP     = 3'd4;
  localparam logic [2:0] OP_FIRE    = 3'd5;

  // Status codes.
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_BAD_ID     = 3'd1;
  localparam logic [2:0] STAT_NOT_ACTIVE = 3'd2;
  localparam logic [2:0] STAT_ALREADY    = 3'd3;
  localparam logic [2:0] STAT_BAD_VALUE  = 3'd4;
  localparam logic [2:0] STAT_EMPTY      = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ID_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_MAX_ALLOWED = 2'd1;
  localparam logic [1:0] CFG_MIN_CYCLE   = 2'd2;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    logic [2:0]  op;
    logic        op_bad;
    logic        id_bad;
    logic        val_bad;
    logic [7:0]  id;
    logic [31:0] cur;
    logic [31:0] expiry;
    logic [31:0] cycle;
  } atq_req_t;

endpackage

// ----- hdl/alarm_timer_queue_unit.sv -----
// Top level of the alarm timer queue: configuration registers, the two halves and the queue between them.
//
// Requests enter on the in_ channel (in_valid/in_stall); each produces exactly one
// result word on the out_ channel (out_valid/out_stall) carrying a status, the
// time left for get, the popped alarm for pop head, and the queue head after the
// request. Configuration registers (alarm count, counter maximum, smallest cycle)
// are written through cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// The front reduces the counter with one subtraction when it is below twice the
// modulus and otherwise runs its remainder unit; the back compares all cells,
// updates the chain and registers the result. The front takes a new request once
// it has pushed the last into the two-word queue; in the common case the back end
// sets the pace.
// After a write of the counter maximum the back rescans the chain once before it
// takes the next request.
// Reset empties the queue, clears all active flags and restores the registers
// to 64 alarms, maximum 2^32-1 and smallest cycle 1. A stalled result holds in
// the output register while the front and the two-word queue keep taking work.
`timescale 1ns / 1ps
module alarm_timer_queue_unit #(
  parameter int MAX_ALARMS = atq_pkg::MAX_ALARMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_value,
  input  logic [31:0] in_cycle,
  input  logic [31:0] in_current,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_remaining,
  output logic [5:0]  out_popped_id,
  output logic [31:0] out_popped_cycle,
  output logic        out_head_valid,
  output logic [5:0]  out_head_id,
  output logic [31:0] out_head_expiry,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import atq_pkg::*;

  logic [6:0]  id_limit_r;
  logic [31:0] max_allowed_r;
  logic [31:0] min_cycle_r;
  logic [31:0] max_eff;
  logic        cfg_wr;
  logic        renorm;
  logic        push;
  logic        pop;
  logic        fifo_full;
  logic        fifo_empty;
  atq_req_t    push_req;
  atq_req_t    fifo_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign renorm    = cfg_wr && (cfg_index == CFG_MAX_ALLOWED);
  assign max_eff   = max_allowed_r & TICK_MASK;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r    <= 7'd64;
      max_allowed_r <= 32'hFFFF_FFFF;
      min_cycle_r   <= 32'd1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ID_LIMIT:    id_limit_r    <= cfg_data[6:0];
        CFG_MAX_ALLOWED: max_allowed_r <= cfg_data;
        CFG_MIN_CYCLE:   min_cycle_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  atq_front #(.MAX_ALARMS(MAX_ALARMS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_timer_id (in_timer_id),
    .in_value    (in_value),
    .in_cycle    (in_cycle),
    .in_current  (in_current),
    .id_limit    (id_limit_r),
    .max_eff     (max_eff),
    .min_cycle   (min_cycle_r),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_req    (push_req)
  );

  atq_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_req),
    .pop   (pop),
    .dout  (fifo_head),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  atq_back #(.MAX_ALARMS(MAX_ALARMS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_empty       (fifo_empty),
    .fifo_head        (fifo_head),
    .fifo_pop         (pop),
    .max_eff          (max_eff),
    .renorm           (renorm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_remaining    (out_remaining),
    .out_popped_id    (out_popped_id),
    .out_popped_cycle (out_popped_cycle),
    .out_head_valid   (out_head_valid),
    .out_head_id      (out_head_id),
    .out_head_expiry  (out_head_expiry)
  );
endmodule

// ----- hdl/atq_mod.sv -----
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module atq_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [32:0] m,
  output logic        busy,
  output logic        done,
  output logic [31:0] rem
);
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] x_r;
  logic [31:0] r_r;
  logic [32:0] trial;
  logic [32:0] r_nxt;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {r_r, x_r[31]};
    if (trial >= m) begin
      r_nxt = trial - m;
    end else begin
      r_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses for one cycle after the last bit.
      done_r <= busy_r && (cnt_r == 5'd0);
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        x_r    <= x;
        r_r    <= '0;
      end else if (busy_r) begin
        r_r   <= r_nxt[31:0];
        x_r   <= {x_r[30:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = r_r;
endmodule

// ----- hdl/atq_front.sv -----
// Front end: takes a request word, reduces the counter and classifies it.
`timescale 1ns / 1ps
module atq_front #(
  parameter int MAX_ALARMS = atq_pkg::MAX_ALARMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [7:0]       in_timer_id,
  input  logic [31:0]      in_value,
  input  logic [31:0]      in_cycle,
  input  logic [31:0]      in_current,
  input  logic [6:0]       id_limit,
  input  logic [31:0]      max_eff,
  input  logic [31:0]      min_cycle,
  input  logic             fifo_full,
  output logic             push,
  output atq_pkg::atq_req_t push_req
);
  import atq_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_NORM = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]  state_r;
  logic [2:0]  op_r;
  logic [7:0]  id_r;
  logic [31:0] val_r;
  logic [31:0] cyc_r;
  logic [31:0] cur_r;
  logic [31:0] curn_r;
  logic [32:0] m;
  logic [32:0] cur_less;
  logic        fast_ok;
  logic [31:0] fast_cur;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_rem;
  logic        div_start;
  logic [32:0] rel_sum;
  logic [31:0] rel_exp;
  logic        cyc_bad;

  assign m = {1'b0, max_eff} + 33'd1;

  // Counters below twice the modulus reduce with one subtraction.
  always_comb begin
    cur_less = {1'b0, cur_r} - m;
    fast_ok  = 1'b1;
    fast_cur = cur_r;
    if ({1'b0, cur_r} >= m) begin
      fast_cur = cur_less[31:0];
      fast_ok  = (cur_less < m);
    end
  end

  assign div_start = (state_r == F_NORM) && !fast_ok;

  atq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (cur_r),
    .m     (m),
    .busy  (div_busy),
    .done  (div_done),
    .rem   (div_rem)
  );

  // Request sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            op_r    <= in_op;
            id_r    <= in_timer_id;
            val_r   <= in_value;
            cyc_r   <= in_cycle;
            cur_r   <= in_current;
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          if (fast_ok) begin
            curn_r  <= fast_cur;
            state_r <= F_PUSH;
          end else begin
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_done && !div_busy) begin
            curn_r  <= div_rem;
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!fifo_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Relative expiry; the sum stays below twice the modulus for legal increments.
  always_comb begin
    rel_sum = {1'b0, curn_r} + {1'b0, val_r};
    if (rel_sum >= m) begin
      rel_sum = rel_sum - m;
    end
    rel_exp = rel_sum[31:0];
  end

  assign cyc_bad = ((cyc_r != 32'd0) && (cyc_r < min_cycle)) || (cyc_r > max_eff);

  // Classification of the held word.
  always_comb begin
    push_req.op      = op_r;
    push_req.op_bad  = (op_r > OP_FIRE);
    push_req.id_bad  = ({1'b0, id_r} >= {2'b00, id_limit}) ||
                       ({1'b0, id_r} >= 9'(MAX_ALARMS));
    push_req.id      = id_r;
    push_req.cur     = curn_r;
    push_req.cycle   = cyc_r;
    push_req.expiry  = val_r;
    push_req.val_bad = cyc_bad || (val_r > max_eff);
    case (op_r)
      OP_SET_REL: begin
        push_req.expiry  = rel_exp;
        push_req.val_bad = cyc_bad || (val_r == 32'd0) || (val_r > max_eff);
      end
      OP_FIRE: begin
        push_req.expiry = curn_r;
        push_req.cycle  = 32'd0;
      end
      default: begin
      end
    endcase
  end

  assign push     = (state_r == F_PUSH) && !fifo_full;
  assign in_stall = (state_r != F_IDLE);
endmodule

// ----- hdl/atq_fifo.sv -----
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
module atq_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atq_pkg::atq_req_t din,
  input  logic              pop,
  output atq_pkg::atq_req_t dout,
  output logic              empty,
  output logic              full
);
  import atq_pkg::*;

  atq_req_t   slot_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wptr_r] <= din;
        wptr_r         <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout  = slot_r[rptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
endmodule

// ----- hdl/atq_back.sv -----
// Back end: ordered cell chain of active alarms, state checks and result word.
`timescale 1ns / 1ps
`include "alarm_timer_queue_unit_assert.svh"
module atq_back #(
  parameter int MAX_ALARMS = atq_pkg::MAX_ALARMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_empty,
  input  atq_pkg::atq_req_t fifo_head,
  output logic              fifo_pop,
  input  logic [31:0]       max_eff,
  input  logic              renorm,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [31:0]       out_remaining,
  output logic [5:0]        out_popped_id,
  output logic [31:0]       out_popped_cycle,
  output logic              out_head_valid,
  output logic [5:0]        out_head_id,
  output logic [31:0]       out_head_expiry
);
  import atq_pkg::*;

  localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int LW = $clog2(MAX_ALARMS + 1);
  localparam int N  = MAX_ALARMS;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CMP   = 3'd1;
  localparam logic [2:0] B_EXEC  = 3'd2;
  localparam logic [2:0] B_OUT   = 3'd3;
  localparam logic [2:0] B_SWEEP = 3'd4;
  localparam logic [2:0] B_SWAIT = 3'd5;

  logic [2:0]    state_r;
  atq_req_t      req_r;
  logic [IW-1:0] cid_r   [N];
  logic [31:0]   cexp_r  [N];
  logic [31:0]   cexpn_r [N];
  logic [31:0]   ccyc_r  [N];
  logic [LW-1:0] qlen_r;
  logic [N-1:0]  flags_r;
  logic [N-1:0]  gt_r;
  logic [N-1:0]  match_r;
  logic          act_r;
  logic          dirty_r;
  logic [LW-1:0] scnt_r;
  logic [2:0]    stat_r;
  logic [31:0]   rem_r;
  logic [IW-1:0] pid_r;
  logic [31:0]   pcyc_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_remaining_r;
  logic [5:0]    out_popped_id_r;
  logic [31:0]   out_popped_cycle_r;
  logic          out_head_valid_r;
  logic [5:0]    out_head_id_r;
  logic [31:0]   out_head_expiry_r;

  logic [32:0]   m;
  logic [IW-1:0] rid;
  logic [31:0]   mine;
  logic [31:0]   tl      [N];
  logic [31:0]   expn_sel;
  logic [31:0]   get_rem;
  logic          do_ins;
  logic          ins_front;
  logic          do_rm;
  logic          rm_head;
  logic          set_flag;
  logic          clr_flag;
  logic [IW-1:0] clr_idx;
  logic [2:0]    stat;
  logic [31:0]   rem;
  logic [N-1:0]  in_len;
  logic [N-1:0]  at_mask;
  logic [N-1:0]  rm_mask;
  logic          div_busy;
  logic          div_done;
  logic [31:0]   div_rem;
  logic          out_free;

  assign m   = {1'b0, max_eff} + 33'd1;
  assign rid = IW'(req_r.id);

  // Ticks left, for an expiry and a counter already below the modulus.
  function automatic logic [31:0] tdiff(input logic [31:0] a, input logic [31:0] c,
                                        input logic [32:0] mm);
    logic [32:0] d;
    if (a >= c) begin
      d = {1'b0, a} - {1'b0, c};
    end else begin
      d = {1'b0, a} + mm - {1'b0, c};
    end
    return d[31:0];
  endfunction

  // Marks every position at or after the first set bit.
  function automatic logic [N-1:0] prefix_or(input logic [N-1:0] v);
    logic [N-1:0] r;
    r = v;
    for (int k = 0; k < IW; k++) begin
      r = r | (r << (1 << k));
    end
    return r;
  endfunction

  // Time left of the request and of each cell, and which cells are in use.
  always_comb begin
    mine = tdiff(req_r.expiry, req_r.cur, m);
    for (int i = 0; i < N; i++) begin
      in_len[i] = (LW'(i) < qlen_r);
      tl[i]     = tdiff(cexpn_r[i], req_r.cur, m);
    end
  end

  // Remaining time of the matched cell.
  always_comb begin
    expn_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (match_r[i]) begin
        expn_sel = expn_sel | cexpn_r[i];
      end
    end
    get_rem = tdiff(expn_sel, req_r.cur, m);
  end

  // Checks in order: request code, identifier (not for pop), state, value (not for fire).
  always_comb begin
    do_ins    = 1'b0;
    ins_front = 1'b0;
    do_rm     = 1'b0;
    rm_head   = 1'b0;
    set_flag  = 1'b0;
    clr_flag  = 1'b0;
    clr_idx   = rid;
    stat      = STAT_OK;
    rem       = '0;
    if (req_r.op_bad) begin
      stat = STAT_BAD_VALUE;
    end else if (req_r.op == OP_POP) begin
      if (qlen_r == '0) begin
        stat = STAT_EMPTY;
      end else begin
        do_rm    = 1'b1;
        rm_head  = 1'b1;
        clr_flag = 1'b1;
        clr_idx  = cid_r[0];
      end
    end else if (req_r.id_bad) begin
      stat = STAT_BAD_ID;
    end else if (req_r.op == OP_GET || req_r.op == OP_CANCEL) begin
      if (!act_r) begin
        stat = STAT_NOT_ACTIVE;
      end else if (req_r.op == OP_GET) begin
        rem = get_rem;
      end else begin
        do_rm    = 1'b1;
        clr_flag = 1'b1;
      end
    end else if (act_r) begin
      stat = STAT_ALREADY;
    end else if (req_r.op == OP_FIRE) begin
      do_ins    = 1'b1;
      ins_front = 1'b1;
      set_flag  = 1'b1;
    end else if (req_r.val_bad) begin
      stat = STAT_BAD_VALUE;
    end else begin
      do_ins   = 1'b1;
      set_flag = 1'b1;
    end
  end

  // Shift masks for insertion and removal.
  always_comb begin
    if (ins_front) begin
      at_mask = '1;
    end else begin
      at_mask = prefix_or(gt_r | ~in_len);
    end
    if (rm_head) begin
      rm_mask = '1;
    end else begin
      rm_mask = prefix_or(match_r);
    end
  end

  atq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_SWEEP),
    .x     (cexp_r[0]),
    .m     (m),
    .busy  (div_busy),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign fifo_pop = (state_r == B_IDLE) && !dirty_r && !renorm && !fifo_empty;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer, cell chain and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      qlen_r  <= '0;
      flags_r <= '0;
      dirty_r <= 1'b0;
      scnt_r  <= '0;
    end else begin
      if (renorm) begin
        dirty_r <= 1'b1;
      end
      unique case (state_r)
        B_IDLE: begin
          if (dirty_r && !renorm) begin
            dirty_r <= 1'b0;
            scnt_r  <= qlen_r;
            if (qlen_r != '0) begin
              state_r <= B_SWEEP;
            end
          end else if (fifo_pop) begin
            req_r   <= fifo_head;
            state_r <= B_CMP;
          end
        end
        B_CMP: begin
          for (int i = 0; i < N; i++) begin
            gt_r[i]    <= in_len[i] && (tl[i] > mine);
            match_r[i] <= in_len[i] && (cid_r[i] == rid);
          end
          act_r   <= flags_r[rid];
          state_r <= B_EXEC;
        end
        B_EXEC: begin
          stat_r <= stat;
          rem_r  <= rem;
          pid_r  <= rm_head ? cid_r[0] : '0;
          pcyc_r <= rm_head ? ccyc_r[0] : '0;
          if (set_flag) begin
            flags_r[rid] <= 1'b1;
          end
          if (clr_flag) begin
            flags_r[clr_idx] <= 1'b0;
          end
          if (do_ins) begin
            qlen_r <= qlen_r + LW'(1);
            for (int i = 0; i < N; i++) begin
              if (at_mask[i] && (i == 0 || !at_mask[(i > 0) ? i - 1 : 0])) begin
                cid_r[i]   <= rid;
                cexp_r[i]  <= req_r.expiry;
                cexpn_r[i] <= req_r.expiry;
                ccyc_r[i]  <= req_r.cycle;
              end else if (at_mask[i] && i > 0) begin
                cid_r[i]   <= cid_r[(i > 0) ? i - 1 : 0];
                cexp_r[i]  <= cexp_r[(i > 0) ? i - 1 : 0];
                cexpn_r[i] <= cexpn_r[(i > 0) ? i - 1 : 0];
                ccyc_r[i]  <= ccyc_r[(i > 0) ? i - 1 : 0];
              end
            end
          end
          if (do_rm) begin
            qlen_r <= qlen_r - LW'(1);
            for (int i = 0; i < N - 1; i++) begin
              if (rm_mask[i]) begin
                cid_r[i]   <= cid_r[i + 1];
                cexp_r[i]  <= cexp_r[i + 1];
                cexpn_r[i] <= cexpn_r[i + 1];
                ccyc_r[i]  <= ccyc_r[i + 1];
              end
            end
          end
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            state_r <= B_IDLE;
          end
        end
        B_SWEEP: begin
          state_r <= B_SWAIT;
        end
        B_SWAIT: begin
          // Rotate the chain by one, the reduced head going to the tail.
          if (div_done && !div_busy) begin
            for (int i = 0; i < N; i++) begin
              if (LW'(i) == qlen_r - LW'(1)) begin
                cid_r[i]   <= cid_r[0];
                cexp_r[i]  <= cexp_r[0];
                cexpn_r[i] <= div_rem;
                ccyc_r[i]  <= ccyc_r[0];
              end else if (LW'(i) < qlen_r - LW'(1) && i < N - 1) begin
                cid_r[i]   <= cid_r[(i < N - 1) ? i + 1 : i];
                cexp_r[i]  <= cexp_r[(i < N - 1) ? i + 1 : i];
                cexpn_r[i] <= cexpn_r[(i < N - 1) ? i + 1 : i];
                ccyc_r[i]  <= ccyc_r[(i < N - 1) ? i + 1 : i];
              end
            end
            scnt_r <= scnt_r - LW'(1);
            if (scnt_r == LW'(1)) begin
              state_r <= B_IDLE;
            end else begin
              state_r <= B_SWEEP;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Output register; the head is read after the chain has settled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_OUT && out_free) begin
        out_valid_r        <= 1'b1;
        out_status_r       <= stat_r;
        out_remaining_r    <= rem_r;
        out_popped_id_r    <= 6'(pid_r);
        out_popped_cycle_r <= pcyc_r;
        out_head_valid_r   <= (qlen_r != '0);
        out_head_id_r      <= (qlen_r != '0) ? 6'(cid_r[0]) : 6'd0;
        out_head_expiry_r  <= (qlen_r != '0) ? cexp_r[0] : 32'd0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_remaining    = out_remaining_r;
  assign out_popped_id    = out_popped_id_r;
  assign out_popped_cycle = out_popped_cycle_r;
  assign out_head_valid   = out_head_valid_r;
  assign out_head_id      = out_head_id_r;
  assign out_head_expiry  = out_head_expiry_r;

  `ATQ_ASSERT_ALWAYS(a_len_bound, qlen_r <= LW'(MAX_ALARMS))
  `ATQ_ASSERT_ALWAYS(a_flags_match_len, $countones(flags_r) == int'(qlen_r))
  `ATQ_ASSERT_NEXT(a_exec_to_out, state_r == B_EXEC, state_r == B_OUT)
endmodule
